// ===== src/hcu_pkg.sv =====
// ---------------------------------------------------------------------------
// hcu_pkg
// Shared types, codes and constants of the hex code point UTF-16 encoder.
// ---------------------------------------------------------------------------
package hcu_pkg;

	localparam int MAX_DIGITS_DEF = 7;
	localparam int DIGIT_W        = 3;
	localparam int UNIT_W         = 16;
	localparam int CHAR_W         = 16;
	localparam int CP_W           = 28;

	localparam logic [CP_W-1:0]   CP_BMP_LO_MAX = 28'h000D7FF;
	localparam logic [CP_W-1:0]   CP_BMP_HI_MIN = 28'h000E000;
	localparam logic [CP_W-1:0]   CP_BMP_HI_MAX = 28'h000FFFF;
	localparam logic [CP_W-1:0]   CP_SUPP_MIN   = 28'h0010000;
	localparam logic [CP_W-1:0]   CP_SUPP_MAX   = 28'h010FFFF;
	localparam logic [UNIT_W-1:0] LEAD_BASE     = 16'hD800;
	localparam logic [UNIT_W-1:0] TRAIL_BASE    = 16'hDC00;
	localparam logic [UNIT_W-1:0] TEN_BIT_MASK  = 16'h03FF;
	// lead = D800 - (10000 >> 10) + (v >> 10)
	localparam logic [UNIT_W-1:0] SURR_LEAD_BIAS = LEAD_BASE - UNIT_W'(CP_SUPP_MIN >> 10);

	typedef enum logic [1:0] {
		OP_ENTER   = 2'd0,
		OP_CHAR    = 2'd1,
		OP_BKSP    = 2'd2,
		OP_CONVERT = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_ENTERED = 2'd1,
		MODE_HEX     = 2'd2
	} mode_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [DIGIT_W-1:0] digit_count;
		logic               accepted;
		logic               unit_valid;
		logic [UNIT_W-1:0]  code_unit;
		logic               bad_code_point;
		logic               last;
	} res_t;

	typedef struct packed {
		res_t              first;
		logic              pair;
		logic [UNIT_W-1:0] trail;
	} step_res_t;

	// returns {is_hex, digit}
	function automatic logic [4:0] hex_decode(input logic [CHAR_W-1:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 16'h0030 && c <= 16'h0039) begin
			r = {1'b1, 4'(c - 16'h0030)};
		end else if (c >= 16'h0041 && c <= 16'h0046) begin
			r = {1'b1, 4'(c - 16'h0037)};
		end else if (c >= 16'h0061 && c <= 16'h0066) begin
			r = {1'b1, 4'(c - 16'h0057)};
		end
		return r;
	endfunction

endpackage

// ===== src/hcu_key_if.sv =====
// ---------------------------------------------------------------------------
// hcu_key_if
// Keystroke channel: valid/ready handshake with opcode and character.
// ---------------------------------------------------------------------------
interface hcu_key_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [15:0] char_code;

	modport source (output valid, output opcode, output char_code, input ready);
	modport sink   (input valid, input opcode, input char_code, output ready);
endinterface

// ===== src/hcu_res_if.sv =====
// ---------------------------------------------------------------------------
// hcu_res_if
// Result channel: valid/ready handshake with entry status and UTF-16 unit.
// ---------------------------------------------------------------------------
interface hcu_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [2:0]  digit_count;
	logic        accepted;
	logic        unit_valid;
	logic [15:0] code_unit;
	logic        bad_code_point;
	logic        last;

	modport source (output valid, output mode, output digit_count, output accepted,
		output unit_valid, output code_unit, output bad_code_point, output last,
		input ready);
	modport sink   (input valid, input mode, input digit_count, input accepted,
		input unit_valid, input code_unit, input bad_code_point, input last,
		output ready);
endinterface

// ===== src/hcu_step.sv =====
// ---------------------------------------------------------------------------
// hcu_step
// Combinational entry step: next mode, digit count and value, plus results.
// ---------------------------------------------------------------------------
module hcu_step
	import hcu_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF,
	localparam int VAL_W = 4 * MAX_DIGITS
) (
	input  op_t                 opcode,
	input  logic [CHAR_W-1:0]   char_code,
	input  mode_t               mode_cur,
	input  logic [DIGIT_W-1:0]  count_cur,
	input  logic [VAL_W-1:0]    value_cur,
	output mode_t               mode_nxt,
	output logic [DIGIT_W-1:0]  count_nxt,
	output logic [VAL_W-1:0]    value_nxt,
	output step_res_t           res
);

	logic [4:0]         hex;
	logic [CP_W-1:0]    cp;
	logic [CP_W-1:0]    shifted;
	logic [DIGIT_W-1:0] count_dec;
	logic               in_bmp;
	logic               in_supp;

	assign hex       = hex_decode(char_code);
	assign cp        = CP_W'(value_cur);
	assign shifted   = (cp << 4) | CP_W'(hex[3:0]);
	assign count_dec = count_cur - DIGIT_W'(1);
	assign in_bmp    = (cp <= CP_BMP_LO_MAX) || (cp >= CP_BMP_HI_MIN && cp <= CP_BMP_HI_MAX);
	assign in_supp   = (cp >= CP_SUPP_MIN) && (cp <= CP_SUPP_MAX);

	always_comb begin
		mode_nxt  = mode_cur;
		count_nxt = count_cur;
		value_nxt = value_cur;
		res       = '0;
		res.first.last = 1'b1;
		unique case (opcode)
			OP_ENTER: begin
				mode_nxt  = MODE_ENTERED;
				count_nxt = '0;
				value_nxt = '0;
			end
			OP_CHAR: begin
				if (mode_cur != MODE_NORMAL && hex[4] && count_cur < DIGIT_W'(MAX_DIGITS)) begin
					mode_nxt  = MODE_HEX;
					count_nxt = count_cur + DIGIT_W'(1);
					value_nxt = shifted[VAL_W-1:0];
					res.first.accepted = 1'b1;
				end
			end
			OP_BKSP: begin
				if (count_cur != '0) begin
					count_nxt = count_dec;
					value_nxt = value_cur >> 4;
					mode_nxt  = (count_dec == '0) ? MODE_ENTERED : MODE_HEX;
				end else begin
					mode_nxt  = MODE_NORMAL;
					count_nxt = '0;
					value_nxt = '0;
				end
			end
			OP_CONVERT: begin
				mode_nxt  = MODE_NORMAL;
				count_nxt = '0;
				value_nxt = '0;
				if (mode_cur != MODE_NORMAL) begin
					if (in_bmp) begin
						res.first.unit_valid = 1'b1;
						res.first.code_unit  = cp[UNIT_W-1:0];
					end else if (in_supp) begin
						res.first.unit_valid = 1'b1;
						res.first.code_unit  = SURR_LEAD_BIAS + UNIT_W'(cp[20:10]);
						res.first.last       = 1'b0;
						res.pair             = 1'b1;
						res.trail            = TRAIL_BASE | (UNIT_W'(cp[9:0]) & TEN_BIT_MASK);
					end else begin
						res.first.bad_code_point = 1'b1;
					end
				end
			end
			default: ;
		endcase
		// results report the state after the step
		res.first.mode        = mode_nxt;
		res.first.digit_count = count_nxt;
	end

endmodule

// ===== src/hcu_out_stage.sv =====
// ---------------------------------------------------------------------------
// hcu_out_stage
// Result register; sends the trail unit of a surrogate pair one transfer later.
// ---------------------------------------------------------------------------
module hcu_out_stage
	import hcu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  step_res_t  step_res,
	output logic       free,
	hcu_res_if.source  res
);

	logic              valid_q;
	logic              pend_q;
	res_t              item_q;
	logic [UNIT_W-1:0] trail_q;
	logic              xfer;

	assign xfer = valid_q && res.ready;
	assign free = !valid_q || (res.ready && !pend_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			pend_q  <= step_res.pair;
		end else if (xfer) begin
			if (pend_q) begin
				pend_q <= 1'b0;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q  <= step_res.first;
			trail_q <= step_res.trail;
		end else if (xfer && pend_q) begin
			item_q.code_unit <= trail_q;
			item_q.last      <= 1'b1;
		end
	end

	assign res.valid          = valid_q;
	assign res.mode           = item_q.mode;
	assign res.digit_count    = item_q.digit_count;
	assign res.accepted       = item_q.accepted;
	assign res.unit_valid     = item_q.unit_valid;
	assign res.code_unit      = item_q.code_unit;
	assign res.bad_code_point = item_q.bad_code_point;
	assign res.last           = item_q.last;

endmodule

// ===== src/hex_codepoint_entry_utf16_encoder_top.sv =====
// ---------------------------------------------------------------------------
// hex_codepoint_entry_utf16_encoder_top
// Hex code point entry machine with UTF-16 encoding of the entered value.
// ---------------------------------------------------------------------------
// Keystrokes arrive on the key channel (enter, character, backspace, convert)
// and land in an input register. Combinational logic then updates mode, digit
// count and value and builds the result, which the result register holds on
// the res channel. Every keystroke gives one result transfer, except a
// convert of a supplementary code point, which gives lead then trail.
// A result passes from the input register through the step logic into the
// result register, which presents it on res.
// Throughput: one keystroke per cycle while res is ready; a surrogate pair
// holds the result register for two transfers, so the next keystroke waits.
// When res is stalled the result register holds, the input register fills,
// and key.ready drops until the result moves on.
// Reset clears the valid flags of both registers and returns the machine to
// normal mode with no digits; no transfer is pending after reset.
// ---------------------------------------------------------------------------
module hex_codepoint_entry_utf16_encoder_top
	import hcu_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	hcu_key_if.sink   key,
	hcu_res_if.source res
);

	localparam int VAL_W = 4 * MAX_DIGITS;

	logic               valid_s1;
	op_t                opcode_s1;
	logic [CHAR_W-1:0]  char_s1;
	mode_t              mode_q;
	logic [DIGIT_W-1:0] count_q;
	logic [VAL_W-1:0]   value_q;
	mode_t              mode_nxt;
	logic [DIGIT_W-1:0] count_nxt;
	logic [VAL_W-1:0]   value_nxt;
	step_res_t          step_res;
	logic               out_free;
	logic               advance;

	assign advance   = valid_s1 && out_free;
	assign key.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key.ready) begin
			valid_s1 <= key.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key.valid && key.ready) begin
			opcode_s1 <= op_t'(key.opcode);
			char_s1   <= key.char_code;
		end
	end

	// entry state moves when the keystroke moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			count_q <= '0;
			value_q <= '0;
		end else if (advance) begin
			mode_q  <= mode_nxt;
			count_q <= count_nxt;
			value_q <= value_nxt;
		end
	end

	hcu_step #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_step (
		.opcode    (opcode_s1),
		.char_code (char_s1),
		.mode_cur  (mode_q),
		.count_cur (count_q),
		.value_cur (value_q),
		.mode_nxt  (mode_nxt),
		.count_nxt (count_nxt),
		.value_nxt (value_nxt),
		.res       (step_res)
	);

	hcu_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.step_res (step_res),
		.free     (out_free),
		.res      (res)
	);

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DIGIT_W'(MAX_DIGITS))
		else $error("digit count above limit");

	a_normal_empty: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_NORMAL |-> count_q == '0 && value_q == '0)
		else $error("normal mode holds digits");

	a_unit_or_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.unit_valid |-> !res.bad_code_point && !res.accepted)
		else $error("unit emitted together with flag or digit accept");

	a_lead_first: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.last |-> res.unit_valid && res.code_unit[15:10] == 6'b110110)
		else $error("non-final result is not a lead surrogate");

	a_trail_follows: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.ready && !res.last |=> res.valid && res.last
			&& res.code_unit[15:10] == 6'b110111)
		else $error("lead surrogate not followed by trail");

endmodule
